// ===== rtl/spq_pkg.sv =====
// Shared constants, codes and control types for the sorted priority queue.
package spq_pkg;

  localparam int unsigned CAPACITY_DEF      = 16;
  localparam int unsigned PRIORITY_BITS_DEF = 8;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic       load_item;
    logic       rd_en;
    logic       wr_en;
    logic       wr_sel_item;
    logic       head_inc;
    logic       count_inc;
    logic       count_dec;
    logic       load_out;
    logic [1:0] out_status;
  } spq_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic greater;
  } spq_sts_t;

endpackage

// ===== rtl/spq_datapath.sv =====
// Circular slot store, item and read registers, occupancy and result registers.
module spq_datapath #(
  parameter int unsigned CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spq_pkg::spq_ctl_t               ctl,
  input  logic [$clog2(CAPACITY)-1:0]     rd_idx,
  input  logic [$clog2(CAPACITY)-1:0]     wr_idx,
  input  logic signed [31:0]              item_value,
  input  logic [7:0]                      item_priority,
  output spq_pkg::spq_sts_t               sts,
  output logic [$clog2(CAPACITY+1)-1:0]   count,
  output logic [1:0]                      status,
  output logic signed [31:0]              out_value,
  output logic [7:0]                      out_priority,
  output logic [4:0]                      occupancy
);
  import spq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PB = PRIORITY_BITS;

  logic [31:0]    mem_value [CAPACITY];
  logic [PB-1:0]  mem_prio  [CAPACITY];

  logic [IW-1:0]  head;
  logic [31:0]    item_val_r;
  logic [PB-1:0]  item_prio_r;
  logic [31:0]    rd_value;
  logic [PB-1:0]  rd_prio;
  logic [31:0]    prio_ext;
  logic [31:0]    rd_prio_ext;
  logic [31:0]    wr_value;
  logic [PB-1:0]  wr_prio;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  wr_addr;

  function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] base,
                                            input logic [IW-1:0] idx);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (IW+1)'(CAPACITY)) begin
      sum = sum - (IW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign prio_ext    = 32'(item_priority);
  assign rd_prio_ext = 32'(rd_prio);
  assign rd_addr     = to_phys(head, rd_idx);
  assign wr_addr     = to_phys(head, wr_idx);
  assign wr_value    = ctl.wr_sel_item ? item_val_r : rd_value;
  assign wr_prio     = ctl.wr_sel_item ? item_prio_r : rd_prio;

  assign sts.empty   = (count == '0);
  assign sts.full    = (count == CW'(CAPACITY));
  assign sts.greater = (rd_prio > item_prio_r);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_value[wr_addr] <= wr_value;
      mem_prio[wr_addr]  <= wr_prio;
    end
    if (ctl.rd_en) begin
      rd_value <= mem_value[rd_addr];
      rd_prio  <= mem_prio[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_val_r  <= item_value;
      item_prio_r <= prio_ext[PB-1:0];
    end
    if (ctl.load_out) begin
      status    <= ctl.out_status;
      occupancy <= 5'(count);
      if (ctl.out_status == ST_DEQUEUED) begin
        out_value    <= rd_value;
        out_priority <= rd_prio_ext[7:0];
      end else begin
        out_value    <= '0;
        out_priority <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (ctl.head_inc) begin
        if (head == IW'(CAPACITY - 1)) begin
          head <= '0;
        end else begin
          head <= head + 1'b1;
        end
      end
      if (ctl.count_inc) begin
        count <= count + 1'b1;
      end else if (ctl.count_dec) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spq_controller.sv =====
// Sequencer for insertion from the tail, head removal and result hand-off.
module spq_controller #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  spq_pkg::spq_sts_t               sts,
  input  logic [$clog2(CAPACITY+1)-1:0]   count,
  output spq_pkg::spq_ctl_t               ctl,
  output logic [$clog2(CAPACITY)-1:0]     rd_idx,
  output logic [$clog2(CAPACITY)-1:0]     wr_idx
);
  import spq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_DEQ   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_next;
  logic [1:0]    st_code;
  logic [1:0]    st_code_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl            = '0;
    ctl.out_status = st_code;
    rd_idx         = '0;
    wr_idx         = IW'(pos);
    state_next     = state;
    pos_next       = pos;
    st_code_next   = st_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          if (cmd == CMD_ENQUEUE) begin
            if (sts.full) begin
              st_code_next = ST_FULL;
              state_next   = S_FIN;
            end else begin
              st_code_next = ST_ENQUEUED;
              pos_next     = count;
              if (sts.empty) begin
                state_next = S_PLACE;
              end else begin
                ctl.rd_en  = 1'b1;
                rd_idx     = IW'(count - 1'b1);
                state_next = S_SCAN;
              end
            end
          end else begin
            if (sts.empty) begin
              st_code_next = ST_EMPTY;
              state_next   = S_FIN;
            end else begin
              st_code_next = ST_DEQUEUED;
              ctl.rd_en    = 1'b1;
              state_next   = S_DEQ;
            end
          end
        end
      end
      S_SCAN: begin
        ctl.wr_en = 1'b1;
        if (sts.greater) begin
          pos_next = pos - 1'b1;
          if (pos == CW'(1)) begin
            state_next = S_PLACE;
          end else begin
            ctl.rd_en = 1'b1;
            rd_idx    = IW'(pos - CW'(2));
          end
        end else begin
          ctl.wr_sel_item = 1'b1;
          ctl.count_inc   = 1'b1;
          state_next      = S_FIN;
        end
      end
      S_PLACE: begin
        ctl.wr_en       = 1'b1;
        ctl.wr_sel_item = 1'b1;
        ctl.count_inc   = 1'b1;
        state_next      = S_FIN;
      end
      S_DEQ: begin
        ctl.head_inc  = 1'b1;
        ctl.count_dec = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      st_code   <= ST_ENQUEUED;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      st_code <= st_code_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos != '0))
    else $error("scan with insertion point at head");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ) |=> (count == $past(count) - 1'b1))
    else $error("dequeue did not reduce occupancy");
`endif

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue top level: controller plus slot datapath.
// Enqueue: scan shifts greater entries back (at most occupancy), the item is placed, finish registers it.
// Dequeue runs the dequeue then finish states; a full or empty rejection goes straight to finish.
// The tail-first insertion scan moves one entry per cycle, reading one slot while writing another.
// One item is in flight at a time; a waiting result does not block the next input transfer.
// Synchronous reset empties the queue; slot contents stay undefined until written.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] item_value,
  input  logic [7:0]         item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] out_value,
  output logic [7:0]         out_priority,
  output logic [4:0]         occupancy
);
  import spq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spq_ctl_t      ctl;
  spq_sts_t      sts;
  logic [CW-1:0] count;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;

  spq_controller #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .count     (count),
    .ctl       (ctl),
    .rd_idx    (rd_idx),
    .wr_idx    (wr_idx)
  );

  spq_datapath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .rd_idx        (rd_idx),
    .wr_idx        (wr_idx),
    .item_value    (item_value),
    .item_priority (item_priority),
    .sts           (sts),
    .count         (count),
    .status        (status),
    .out_value     (out_value),
    .out_priority  (out_priority),
    .occupancy     (occupancy)
  );

endmodule

// ===== sim/sorted_priority_queue_test.sv =====
// Self-checking testbench for the sorted priority queue, with a scoreboard and random idling.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned DEPTH       = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] val;
    logic [7:0]         pri;
  } request_t;

  typedef struct packed {
    logic [1:0]         st;
    logic signed [31:0] val;
    logic [7:0]         pri;
    logic [4:0]         occ;
  } reply_t;

  class queue_scoreboard;
    logic signed [31:0] slot_val [DEPTH];
    logic [7:0]         slot_pri [DEPTH];
    int unsigned        fill;
    reply_t             pending_replies [$];
    int unsigned        failures;
    int unsigned        n_enq, n_deq, n_empty, n_full;

    function new();
      fill = 0;
      failures = 0;
      n_enq = 0;
      n_deq = 0;
      n_empty = 0;
      n_full = 0;
    endfunction

    function void note_request(request_t r);
      reply_t      rep;
      int unsigned pos;
      rep = '{st: ST_ENQUEUED, val: '0, pri: '0, occ: '0};
      if (r.op == CMD_ENQUEUE) begin
        if (fill >= DEPTH) begin
          rep.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill && slot_pri[pos] <= r.pri) pos++;
          for (int unsigned k = fill; k > pos; k--) begin
            slot_val[k] = slot_val[k - 1];
            slot_pri[k] = slot_pri[k - 1];
          end
          slot_val[pos] = r.val;
          slot_pri[pos] = r.pri;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          rep.st = ST_EMPTY;
        end else begin
          rep.st  = ST_DEQUEUED;
          rep.val = slot_val[0];
          rep.pri = slot_pri[0];
          for (int unsigned k = 1; k < fill; k++) begin
            slot_val[k - 1] = slot_val[k];
            slot_pri[k - 1] = slot_pri[k];
          end
          fill--;
        end
      end
      rep.occ = 5'(fill);
      pending_replies.push_back(rep);
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: status %0d value %0d priority %0d occupancy %0d",
               got.st, got.val, got.pri, got.occ);
        failures++;
        return;
      end
      exp = pending_replies.pop_front();
      if (got.st !== exp.st) begin
        $error("status: expected %0d, got %0d", exp.st, got.st);
        failures++;
      end
      if (got.val !== exp.val) begin
        $error("out_value: expected %0d, got %0d", exp.val, got.val);
        failures++;
      end
      if (got.pri !== exp.pri) begin
        $error("out_priority: expected %0d, got %0d", exp.pri, got.pri);
        failures++;
      end
      if (got.occ !== exp.occ) begin
        $error("occupancy: expected %0d, got %0d", exp.occ, got.occ);
        failures++;
      end
      case (exp.st)
        ST_ENQUEUED: n_enq++;
        ST_DEQUEUED: n_deq++;
        ST_EMPTY:    n_empty++;
        default:     n_full++;
      endcase
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               cmd           = CMD_ENQUEUE;
  logic signed [31:0] item_value    = '0;
  logic [7:0]         item_priority = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] out_value;
  logic [7:0]         out_priority;
  logic [4:0]         occupancy;

  queue_scoreboard sb;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_request   = 0;
  int unsigned     hold_left      = 0;
  int unsigned     cycles         = 0;

  sorted_priority_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .item_value    (item_value),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_value     (out_value),
    .out_priority  (out_priority),
    .occupancy     (occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_priority_queue_test failed");
      $finish;
    end
  end

  // check each result transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_reply('{st: status, val: out_value, pri: out_priority, occ: occupancy});
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(logic op, logic signed [31:0] val, logic [7:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= op;
    item_value    <= val;
    item_priority <= pri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request('{op: op, val: val, pri: pri});
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  // bursts of enqueues and dequeues drive the queue between empty and full
  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    logic        op;
    logic [7:0]  pri;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      len  = $urandom_range(20, 1);
      repeat (len) begin
        if (kind < 45) op = CMD_ENQUEUE;
        else if (kind < 90) op = CMD_DEQUEUE;
        else op = 1'($urandom);
        pri = ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
        send_request(op, $urandom, pri);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(CMD_DEQUEUE, 32'sh7fffffff, 8'hff);
    send_request(CMD_ENQUEUE, 32'sh7fffffff, 8'd255);
    send_request(CMD_ENQUEUE, 32'sh80000000, 8'd0);
    send_request(CMD_ENQUEUE, 32'sh0, 8'd128);
    send_request(CMD_ENQUEUE, -32'sd1, 8'd0);
    send_request(CMD_ENQUEUE, 32'sd5, 8'd255);
    for (int i = 0; i < 11; i++) begin
      send_request(CMD_ENQUEUE, $urandom, 8'(i * 23));
    end
    send_request(CMD_ENQUEUE, 32'sd1234, 8'd0);
    repeat (4) send_request(CMD_DEQUEUE, $urandom, 8'($urandom));
    pause_until_drained();

    // long receiver hold-off while items keep coming
    hold_request = 200;
    repeat (40) send_request(CMD_ENQUEUE, $urandom, 8'($urandom_range(7)));
    pause_until_drained();

    run_random(445);
    send_idle_pct = 57;
    run_random(445);
    pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    run_random(445);
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    run_random(445);

    pause_until_drained();
    repeat (40) @(posedge clk);
    $display("results seen: %0d enqueued, %0d dequeued, %0d empty dequeues, %0d dropped enqueues",
             sb.n_enq, sb.n_deq, sb.n_empty, sb.n_full);
    $display("idling phases: none, sender 57%%, receiver 57%%, both 26%%, plus a long hold-off");
    if (sb.failures == 0) begin
      $display("sorted_priority_queue_test passed");
    end else begin
      $display("sorted_priority_queue_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_controller.sv
rtl/sorted_priority_queue.sv
sim/sorted_priority_queue_test.sv
